// ===== rtl/core/equal_interval_classifier_assert.svh =====
// ----------------------------------------------------------------------------
// Equal-interval classifier assertion macros
// Shared property forms for the classifier's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef EQUAL_INTERVAL_CLASSIFIER_ASSERT_SVH
`define EQUAL_INTERVAL_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EIC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("equal_interval_classifier: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EIC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("equal_interval_classifier: next-cycle check failed");

`endif

// ===== rtl/core/eic_pkg.sv =====
// ----------------------------------------------------------------------------
// Equal-interval classifier package
// Opcodes, sequencer states and the divider status bundle.
// ----------------------------------------------------------------------------
package eic_pkg;

  localparam int OPCODE_BITS = 2;
  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 8;
  localparam int COUNT_W     = 9;

  localparam logic [OPCODE_BITS-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_ACCUM    = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_CLASSIFY = 2'd2;

  localparam logic [COUNT_W-1:0] CLASS_COUNT_RESET = 9'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SPAN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/core/eic_item_if.sv =====
// ----------------------------------------------------------------------------
// Classifier request channel
// Valid/ready channel carrying an opcode and a Q16.16 value.
// ----------------------------------------------------------------------------
interface eic_item_if;

  logic                                valid;
  logic                                ready;
  logic [eic_pkg::OPCODE_BITS-1:0]     opcode;
  logic signed [eic_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);

endinterface

// ===== rtl/core/eic_result_if.sv =====
// ----------------------------------------------------------------------------
// Classifier result channel
// Valid/ready channel carrying a class index and the no-range flag.
// ----------------------------------------------------------------------------
interface eic_result_if;

  logic                            valid;
  logic                            ready;
  logic [eic_pkg::INDEX_W-1:0]     class_index;
  logic                            no_range;

  modport source (output valid, output class_index, output no_range, input ready);
  modport sink   (input valid, input class_index, input no_range, output ready);

endinterface

// ===== rtl/core/eic_div.sv =====
// ----------------------------------------------------------------------------
// Classifier divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eic_div #(
  parameter int NUM_BITS = 41,
  parameter int DEN_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NUM_BITS-1:0]         num,
  input  logic [DEN_BITS-1:0]         den,
  output logic [NUM_BITS-1:0]         quotient,
  output eic_pkg::div_status_t        status
);

  localparam int CNT_BITS = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] rem;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;

  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // Shift the next numerator bit into the partial remainder and trial-subtract.
  assign trial = {rem, quo[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_BITS'(NUM_BITS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NUM_BITS-2:0], fits};
      rem <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== rtl/core/equal_interval_classifier.sv =====
// ----------------------------------------------------------------------------
// Equal-interval classifier
// Tracks the min/max of accumulated Q16.16 values and bins classify requests
// into class_count equal-width classes, clamped to the top class.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake        payload
//   --------  ---  ---------------  ------------------------------------------
//   item      in   valid / ready    opcode[1:0], value[31:0] (signed Q16.16)
//   result    out  valid / ready    class_index[7:0], no_range
//   cfg       in   cfg_write        cfg_data[8:0] -> class_count
//
// Clear and accumulate requests are handled in IDLE; the block is ready again on
// the next cycle. A classify request on an empty or flat range goes from IDLE
// straight to DONE, and one at or below the minimum ends after the subtract in
// DIFF. Otherwise it steps through DIFF, SPAN, MUL, DIV and DONE, its length
// set by the restoring divider, which resolves one quotient bit per cycle.
// Reset is synchronous: range cleared, class_count back to 2, no result held.
// The result register parts the two sides: a new request is taken while a
// result waits; a finished classify holds in DONE until the register is free.
// ----------------------------------------------------------------------------
`include "equal_interval_classifier_assert.svh"

module equal_interval_classifier #(
  parameter int VALUE_BITS  = 32,
  parameter int MAX_CLASSES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  eic_item_if.sink                    item,
  eic_result_if.source                result,
  input  logic                        cfg_write,
  input  logic [eic_pkg::COUNT_W-1:0] cfg_data
);

  // Effective class limit: the parameter, capped by the 8-bit index.
  localparam int CLASS_LIMIT = (MAX_CLASSES < 256) ? MAX_CLASSES : 256;
  localparam int CLS_BITS    = $clog2(CLASS_LIMIT + 1);
  localparam int NUM_BITS    = VALUE_BITS + CLS_BITS;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  eic_pkg::state_t                  state;
  eic_pkg::state_t                  state_next;

  logic [eic_pkg::COUNT_W-1:0]      class_count;
  logic signed [VALUE_BITS-1:0]     range_min;
  logic signed [VALUE_BITS-1:0]     range_max;
  logic                             range_valid;

  logic signed [VALUE_BITS-1:0]     operand;   // value of the classify request
  logic [VALUE_BITS-1:0]            diff;      // value - min, known positive
  logic [VALUE_BITS-1:0]            span;      // max - min, known positive
  logic [NUM_BITS-1:0]              numer;     // diff * classes
  logic [eic_pkg::INDEX_W-1:0]      res_index;
  logic                             res_flag;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic [63:0]                      value_wide;
  logic signed [VALUE_BITS-1:0]     value_in;
  logic                             accept;
  logic                             classify_in;
  logic                             flat;

  // Sign-extend the port, then keep the low VALUE_BITS as a signed value.
  assign value_wide  = {{32{item.value[31]}}, item.value};
  assign value_in    = value_wide[VALUE_BITS-1:0];
  assign accept      = item.valid && item.ready;
  assign classify_in = accept && (item.opcode == eic_pkg::OP_CLASSIFY);
  assign flat        = !range_valid || (range_max == range_min);

  // --------------------------------------------------------------------------
  // Effective class count: below 2 acts as 2, above the limit as the limit
  // --------------------------------------------------------------------------
  logic [CLS_BITS-1:0]              cls_eff;

  always_comb begin
    if (class_count < 9'd2) begin
      cls_eff = CLS_BITS'(2);
    end else if (class_count > 9'(CLASS_LIMIT)) begin
      cls_eff = CLS_BITS'(CLASS_LIMIT);
    end else begin
      cls_eff = CLS_BITS'(class_count);
    end
  end

  // --------------------------------------------------------------------------
  // Shared subtractor: value - min in DIFF, max - min in SPAN
  // --------------------------------------------------------------------------
  logic                             sel_span;
  logic signed [VALUE_BITS-1:0]     sub_a;
  logic [VALUE_BITS:0]              sub_res;
  logic                             sub_pos;

  assign sub_a   = sel_span ? range_max : operand;
  assign sub_res = {sub_a[VALUE_BITS-1], sub_a} - {range_min[VALUE_BITS-1], range_min};
  assign sub_pos = !sub_res[VALUE_BITS] && (sub_res != '0);

  // --------------------------------------------------------------------------
  // Scale by the class count and divide by the span
  // --------------------------------------------------------------------------
  logic [NUM_BITS-1:0]              product;
  logic [NUM_BITS-1:0]              quotient;
  eic_pkg::div_status_t             div_status;
  logic                             div_start;
  logic                             over_top;

  assign product  = NUM_BITS'(diff) * NUM_BITS'(cls_eff);
  assign over_top = (quotient >= NUM_BITS'(cls_eff));

  eic_div #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (numer),
    .den      (span),
    .quotient (quotient),
    .status   (div_status)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  logic                             out_free;

  assign out_free = !result.valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      eic_pkg::S_IDLE: begin
        if (classify_in) begin
          state_next = flat ? eic_pkg::S_DONE : eic_pkg::S_DIFF;
        end
      end
      eic_pkg::S_DIFF: begin
        // Values at or below the minimum fall in class 0 without dividing.
        state_next = sub_pos ? eic_pkg::S_SPAN : eic_pkg::S_DONE;
      end
      eic_pkg::S_SPAN: state_next = eic_pkg::S_MUL;
      eic_pkg::S_MUL:  state_next = eic_pkg::S_DIV;
      eic_pkg::S_DIV: begin
        if (div_status.done) begin
          state_next = eic_pkg::S_DONE;
        end
      end
      eic_pkg::S_DONE: begin
        if (out_free) begin
          state_next = eic_pkg::S_IDLE;
        end
      end
      default: state_next = eic_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  logic                             out_load;

  always_comb begin
    item.ready = 1'b0;
    sel_span   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      eic_pkg::S_IDLE: item.ready = 1'b1;
      eic_pkg::S_DIFF: sel_span   = 1'b0;
      eic_pkg::S_SPAN: sel_span   = 1'b1;
      eic_pkg::S_MUL:  div_start  = 1'b1;
      eic_pkg::S_DIV:  sel_span   = 1'b0;
      eic_pkg::S_DONE: out_load   = out_free;
      default:         item.ready = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and range state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= eic_pkg::S_IDLE;
      class_count <= eic_pkg::CLASS_COUNT_RESET;
      range_min   <= '0;
      range_max   <= '0;
      range_valid <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        class_count <= cfg_data;
      end

      if (accept) begin
        case (item.opcode)
          eic_pkg::OP_CLEAR: begin
            range_min   <= '0;
            range_max   <= '0;
            range_valid <= 1'b0;
          end
          eic_pkg::OP_ACCUM: begin
            // The first value sets both bounds; later ones widen them.
            if (!range_valid) begin
              range_min   <= value_in;
              range_max   <= value_in;
              range_valid <= 1'b1;
            end else begin
              if (value_in < range_min) begin
                range_min <= value_in;
              end
              if (value_in > range_max) begin
                range_max <= value_in;
              end
            end
          end
          default: begin
            // Classify leaves the range alone; the unused opcode is dropped.
          end
        endcase
      end

      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      operand   <= value_in;
      res_index <= '0;
      res_flag  <= flat;
    end

    if (state == eic_pkg::S_DIFF) begin
      diff <= sub_res[VALUE_BITS-1:0];
    end

    // Hold the scaled difference ready for the divider start in MUL.
    if (state == eic_pkg::S_SPAN) begin
      span  <= sub_res[VALUE_BITS-1:0];
      numer <= product;
    end

    // Clamp to the top class so the maximum itself lands there.
    if ((state == eic_pkg::S_DIV) && div_status.done) begin
      res_index <= over_top ? eic_pkg::INDEX_W'(cls_eff - 1'b1)
                            : eic_pkg::INDEX_W'(quotient);
    end

    if (out_load) begin
      result.class_index <= res_index;
      result.no_range    <= res_flag;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `EIC_ASSERT_NOW(a_flag_forces_zero, clk, rst, result.valid && result.no_range, result.class_index == '0)
  `EIC_ASSERT_NOW(a_index_below_classes, clk, rst, result.valid, 9'(result.class_index) < 9'(cls_eff))
  `EIC_ASSERT_NEXT(a_flat_skips_divider, clk, rst, classify_in && flat, state == eic_pkg::S_DONE)
  `EIC_ASSERT_NOW(a_divisor_nonzero, clk, rst, state == eic_pkg::S_DIV, span != '0)

endmodule

// ===== test/eic_bin_check.sv =====
// ----------------------------------------------------------------------------
// Equal-interval classifier bin checker
// Watches the request, result and configuration ports, keeps its own copy of
// the running range and class count, and compares every result with the bin
// predicted when its classify request was taken.
// ----------------------------------------------------------------------------
module eic_bin_check #(
  parameter int MAX_CLASSES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  eic_item_if                         item,
  eic_result_if                       result,
  input  logic                        cfg_write,
  input  logic [eic_pkg::COUNT_W-1:0] cfg_data,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [eic_pkg::INDEX_W-1:0] class_index;
    logic                        no_range;
  } bin_t;

  bin_t                                pending_bins[$];
  bin_t                                want;
  logic [eic_pkg::COUNT_W-1:0]         class_count;
  logic signed [eic_pkg::VALUE_W-1:0]  range_min;
  logic signed [eic_pkg::VALUE_W-1:0]  range_max;
  logic                                range_seen;
  int                                  fail_count = 0;

  assign mismatches = fail_count;

  initial outstanding = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] bin check: %s", $realtime, msg);
    fail_count++;
  endtask

  // Bin a value against the range as it stands when the request is taken.
  function automatic bin_t predict_bin(logic signed [eic_pkg::VALUE_W-1:0] v);
    int     classes;
    longint diff;
    longint span;
    longint quot;
    bin_t   b;
    classes = class_count;
    if (classes < 2) classes = 2;
    if (classes > MAX_CLASSES) classes = MAX_CLASSES;
    if (classes > 256) classes = 256;
    b = '0;
    if (!range_seen || range_max == range_min) begin
      b.no_range = 1'b1;
    end else begin
      diff = longint'(v) - longint'(range_min);
      span = longint'(range_max) - longint'(range_min);
      if (diff > 0) begin
        quot = (diff * classes) / span;
        if (quot > classes - 1) quot = classes - 1;
        b.class_index = quot[eic_pkg::INDEX_W-1:0];
      end
    end
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      class_count = eic_pkg::CLASS_COUNT_RESET;
      range_min   = '0;
      range_max   = '0;
      range_seen  = 1'b0;
      pending_bins.delete();
    end else begin
      // Retire the result first: it can never belong to a request taken now.
      if (result.valid && result.ready) begin
        if (pending_bins.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0b with no classify waiting",
                                    result.class_index, result.no_range));
        end else begin
          want = pending_bins.pop_front();
          if (result.class_index !== want.class_index)
            report_mismatch($sformatf("class_index %0d, expected %0d",
                                      result.class_index, want.class_index));
          if (result.no_range !== want.no_range)
            report_mismatch($sformatf("no_range %0b, expected %0b",
                                      result.no_range, want.no_range));
        end
      end
      if (item.valid && item.ready) begin
        case (item.opcode)
          eic_pkg::OP_CLEAR: begin
            range_min  = '0;
            range_max  = '0;
            range_seen = 1'b0;
          end
          eic_pkg::OP_ACCUM: begin
            if (!range_seen) begin
              range_min  = item.value;
              range_max  = item.value;
              range_seen = 1'b1;
            end else begin
              if (item.value < range_min) range_min = item.value;
              if (item.value > range_max) range_max = item.value;
            end
          end
          eic_pkg::OP_CLASSIFY: begin
            pending_bins = {pending_bins, predict_bin(item.value)};
          end
          default: begin
          end
        endcase
      end
      if (cfg_write) class_count = cfg_data;
    end
    outstanding <= pending_bins.size();
  end

endmodule

// ===== test/tb_equal_interval_classifier.sv =====
// ----------------------------------------------------------------------------
// Equal-interval classifier testbench
// Drives clear, accumulate and classify requests with random gaps on both
// channels through several class counts, extremes included; the bin checker
// predicts and compares, this module builds stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_equal_interval_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous watchdog limit on the whole run.
  localparam int RUN_LIMIT     = 600_000;
  // Let any straggling classify finish before a class-count write.
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 150;
  localparam int PHASES        = 9;
  // The one opcode the block must ignore.
  localparam logic [eic_pkg::OPCODE_BITS-1:0] OP_RESERVED = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_write;
  logic [eic_pkg::COUNT_W-1:0] cfg_data;
  int                          mismatches;
  int                          outstanding;
  bit                          steady;
  int                          sent;
  longint                      cycles = 0;
  logic [eic_pkg::COUNT_W-1:0] count_plan [PHASES];

  eic_item_if   item_ch ();
  eic_result_if result_ch ();

  equal_interval_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  eic_bin_check bin_check (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("equal_interval_classifier: mismatch");
      $finish;
    end
  end

  // In a steady stretch neither side idles; otherwise draw a fresh gap.
  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  // Offer one request after a random gap and hold it until taken. Valid is
  // only ever given one assignment per falling edge, so back-to-back requests
  // keep it high without a glitch.
  task automatic send(logic [eic_pkg::OPCODE_BITS-1:0] op,
                      logic [eic_pkg::VALUE_W-1:0] v);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid  <= 1'b1;
    item_ch.opcode <= op;
    item_ch.value  <= v;
    do @(posedge clk); while (!item_ch.ready);
    if (op != OP_RESERVED) sent++;
  endtask

  // Drop valid, wait for every predicted result, then let the block go idle.
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_class_count(logic [eic_pkg::COUNT_W-1:0] count);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= count;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One burst of requests. Mostly a well-formed pass: clear, accumulate a
  // handful of values around a random base, then classify values inside,
  // below and above that range, some of them exactly the accumulated values.
  // The rest is noise with any opcode, or a broken pass that widens the old
  // range (or classifies against it unchanged) without starting afresh.
  task automatic random_burst();
    logic [eic_pkg::VALUE_W-1:0] base;
    logic [eic_pkg::VALUE_W-1:0] spread;
    logic [eic_pkg::VALUE_W-1:0] lo;
    logic [eic_pkg::VALUE_W-1:0] v;
    logic [eic_pkg::VALUE_W-1:0] seen [$];
    int                          kind;
    int                          n_acc;
    kind   = $urandom_range(0, 9);
    steady = ($urandom_range(0, 5) == 0);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6))
        send(eic_pkg::OPCODE_BITS'($urandom_range(0, 3)), $urandom);
    end else begin
      base   = $urandom;
      // Spread mask from zero up to the full 32-bit range.
      spread = eic_pkg::VALUE_W'((64'd1 << $urandom_range(0, 32)) - 1);
      if (kind != 1) send(eic_pkg::OP_CLEAR, $urandom);
      n_acc = (kind == 1) ? $urandom_range(0, 3) : $urandom_range(1, 8);
      repeat (n_acc) begin
        v = base + ($urandom & spread);
        seen = {seen, v};
        send(eic_pkg::OP_ACCUM, v);
      end
      lo = base - (spread >> 3);
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 7))
          0, 1: v = (seen.size() != 0) ? seen[$urandom_range(0, seen.size() - 1)]
                                       : $urandom;
          2: v = $urandom;
          default: v = lo + ($urandom & spread) + ($urandom & (spread >> 2));
        endcase
        send(eic_pkg::OP_CLASSIFY, v);
      end
    end
  endtask

  // Result side: either keep ready up, or hold it low until a result shows
  // and then stall it over the drawn gap.
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    forever begin
      gap = draw_gap();
      if (gap == 0) begin
        @(negedge clk);
        result_ch.ready <= 1'b1;
      end else begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (!result_ch.valid);
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
        result_ch.ready <= 1'b1;
      end
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_data       = '0;
    item_ch.valid  = 1'b0;
    item_ch.opcode = eic_pkg::OP_CLEAR;
    item_ch.value  = '0;
    steady         = 1'b0;
    sent           = 0;
    count_plan     = '{9'd256, 9'd0, 9'd3, 9'd511, 9'd1, 9'd257, 9'd2, 9'd7, 9'd2};
    count_plan[PHASES-1] = eic_pkg::COUNT_W'($urandom_range(2, 256));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass at the reset class count of two.
    send(eic_pkg::OP_CLASSIFY, 32'h0000_0000);   // nothing accumulated: no range
    send(OP_RESERVED,          32'h7FFF_FFFF);   // ignored, must not open a range
    send(eic_pkg::OP_CLASSIFY, 32'h1234_5678);
    send(eic_pkg::OP_ACCUM,    32'h0005_0000);   // 5.0 sets both bounds
    send(eic_pkg::OP_CLASSIFY, 32'h0005_0000);   // flat range
    send(eic_pkg::OP_ACCUM,    32'h8000_0000);   // most negative value
    send(eic_pkg::OP_ACCUM,    32'h7FFF_FFFF);   // most positive value
    send(eic_pkg::OP_CLASSIFY, 32'h8000_0000);   // the minimum: bottom class
    send(eic_pkg::OP_CLASSIFY, 32'h7FFF_FFFF);   // the maximum: top class
    send(eic_pkg::OP_CLASSIFY, 32'h0000_0000);
    send(eic_pkg::OP_CLASSIFY, 32'hFFFF_FFFF);
    send(OP_RESERVED,          32'h0000_0000);   // ignored, must not clear
    send(eic_pkg::OP_CLASSIFY, 32'h7FFF_FFFF);
    send(eic_pkg::OP_CLEAR,    32'hFFFF_FFFF);
    send(eic_pkg::OP_CLASSIFY, 32'h0000_0000);   // cleared: no range again
    send(eic_pkg::OP_ACCUM,    32'h0003_0000);   // 3.0
    send(eic_pkg::OP_ACCUM,    32'h0001_0000);   // 1.0 widens downward
    send(eic_pkg::OP_CLASSIFY, 32'h0000_8000);   // below the minimum
    send(eic_pkg::OP_CLASSIFY, 32'h0005_0000);   // above the maximum: clamp to top
    send(eic_pkg::OP_CLASSIFY, 32'h0003_0000);   // exactly the maximum
    send(eic_pkg::OP_CLASSIFY, 32'h0001_0000);   // exactly the minimum
    send(eic_pkg::OP_CLASSIFY, 32'h0002_0000);   // exactly on the class boundary
    send(eic_pkg::OP_CLASSIFY, 32'h0001_FFFF);   // one LSB under it
    send(eic_pkg::OP_CLEAR,    32'h0000_0000);
    settle();

    // Random phases, each under its own class count.
    foreach (count_plan[i]) begin
      program_class_count(count_plan[i]);
      sent = 0;
      while (sent < PHASE_ITEMS) random_burst();
      steady = 1'b0;
      settle();
    end

    if (mismatches == 0) begin
      $display("equal_interval_classifier: match");
    end else begin
      $display("equal_interval_classifier: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/eic_pkg.sv
rtl/core/eic_item_if.sv
rtl/core/eic_result_if.sv
rtl/core/eic_div.sv
rtl/core/equal_interval_classifier.sv
test/eic_bin_check.sv
test/tb_equal_interval_classifier.sv
